@@ design/nearest_seed_color_lookup_core_macros.svh @@
// Assertion macros for the nearest seed color lookup core.
// Included by the top level; no other dependencies.
`ifndef NEAREST_SEED_COLOR_LOOKUP_CORE_MACROS_SVH
`define NEAREST_SEED_COLOR_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define NSCL_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nscl: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define NSCL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nscl: next-cycle check failed");

`endif

@@ design/nscl_pkg.sv @@
// Shared types and constants for the nearest seed color lookup core.
// No dependencies; imported by the interfaces and all modules.
package nscl_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SEEDS  = 64;
    localparam int DEF_COORD_BITS = 12;

    // Fixed field widths
    localparam int SLOT_W       = 6;
    localparam int COLOR_W      = 8;
    localparam int OFFSET_W     = 26;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int SEED_COUNT_W = 7;
    localparam int DIM_W        = 13;

    // Image dimensions saturate at this size
    localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;
    localparam logic [DIM_W-1:0] DIM_RESET = 13'd512;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SEEDS = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED_COUNT   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic write;     // store a seed entry
        logic start;     // latch a pixel and set up the scan
        logic issue;     // read the next seed entry
        logic load_out;  // move the result into the output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_pixel;  // offered item is a pixel query
        logic skip;      // pixel outside image or no seeds to scan
        logic last;      // current read address is the last seed
        logic pipe_busy; // distance pipeline still holds entries
        logic out_free;  // output register can take a result
    } t_dp_status;

endpackage

@@ design/nscl_req_if.sv @@
// Input channel: valid/ready handshake carrying a load or pixel item.
// Depends on nscl_pkg.
interface nscl_req_if
    import nscl_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [SLOT_W-1:0]     seed_slot;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [COLOR_W-1:0]    red_in;
    logic [COLOR_W-1:0]    green_in;
    logic [COLOR_W-1:0]    blue_in;

    modport source (
        output valid, command, seed_slot, coord_x, coord_y, red_in, green_in, blue_in,
        input  ready
    );

    modport sink (
        input  valid, command, seed_slot, coord_x, coord_y, red_in, green_in, blue_in,
        output ready
    );
endinterface

@@ design/nscl_rsp_if.sv @@
// Output channel: valid/ready handshake carrying one color result.
// Depends on nscl_pkg.
interface nscl_rsp_if
    import nscl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [OFFSET_W-1:0] pixel_offset;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, red, green, blue, pixel_offset, status,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, pixel_offset, status,
        output ready
    );
endinterface

@@ design/nscl_ctrl.sv @@
// Sequencer for the seed scan: accepts items, steps the read address,
// waits for the pipeline to drain and hands the result over. Uses nscl_pkg.
module nscl_ctrl
    import nscl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_status.is_pixel) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.skip) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                    if (i_status.last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

endmodule

@@ design/nscl_dp.sv @@
// Datapath: configuration registers, seed memory, distance pipeline,
// running minimum, offset arithmetic and output register. Uses nscl_pkg.
module nscl_dp
    import nscl_pkg::*;
#(
    parameter int MAX_SEEDS  = DEF_MAX_SEEDS,
    parameter int COORD_BITS = DEF_COORD_BITS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_command,
    input  logic [SLOT_W-1:0]     i_seed_slot,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic [COLOR_W-1:0]    i_red_in,
    input  logic [COLOR_W-1:0]    i_green_in,
    input  logic [COLOR_W-1:0]    i_blue_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COLOR_W-1:0]    o_red,
    output logic [COLOR_W-1:0]    o_green,
    output logic [COLOR_W-1:0]    o_blue,
    output logic [OFFSET_W-1:0]   o_pixel_offset,
    output t_status               o_status_code
);

    localparam int ADDR_W  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEEDS + 1);
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = 2 * COORD_BITS + 1;
    localparam int RGB_W   = 3 * COLOR_W;
    localparam int ENTRY_W = 2 * COORD_BITS + RGB_W;

    // Configuration registers
    logic [SEED_COUNT_W-1:0] r_seed_count;
    logic [DIM_W-1:0]        r_width;
    logic [DIM_W-1:0]        r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_count <= '0;
            r_width      <= DIM_RESET;
            r_height     <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SEED_COUNT:   r_seed_count <= i_cfg_wdata[SEED_COUNT_W-1:0];
                REG_IMAGE_WIDTH:  r_width      <= i_cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_height     <= i_cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated dimensions and scan length
    logic [DIM_W-1:0] w_sat;
    logic [DIM_W-1:0] h_sat;
    logic [CNT_W-1:0] scan_cnt;
    logic             oob;

    assign w_sat    = (r_width  > DIM_LIMIT) ? DIM_LIMIT : r_width;
    assign h_sat    = (r_height > DIM_LIMIT) ? DIM_LIMIT : r_height;
    assign scan_cnt = (32'(r_seed_count) > MAX_SEEDS) ? CNT_W'(MAX_SEEDS)
                                                       : CNT_W'(r_seed_count);
    assign oob      = (32'(i_coord_x) >= 32'(w_sat)) || (32'(i_coord_y) >= 32'(h_sat));

    // Pixel context, latched when a pixel item is accepted
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic                  r_oob;
    logic                  r_empty;
    logic [ADDR_W-1:0]     r_last;
    logic [OFFSET_W-1:0]   r_prod;
    logic [OFFSET_W-1:0]   r_base;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px    <= i_coord_x;
            r_py    <= i_coord_y;
            r_oob   <= oob;
            r_empty <= (scan_cnt == '0);
            r_last  <= ADDR_W'(scan_cnt - CNT_W'(1));
            r_prod  <= OFFSET_W'(i_coord_y) * OFFSET_W'(w_sat);
        end
        // row base plus column, registered from the latched product and column
        r_base <= r_prod + OFFSET_W'(r_px);
    end

    // Read address counter
    logic [ADDR_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Seed memory: one write or one read per cycle, registered read data
    logic [ENTRY_W-1:0] mem [MAX_SEEDS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               slot_ok;
    logic [ADDR_W-1:0]  wr_addr;

    assign slot_ok = (32'(i_seed_slot) < MAX_SEEDS);
    assign wr_addr = ADDR_W'(i_seed_slot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && slot_ok) begin
            mem[wr_addr] <= {i_coord_x, i_coord_y, i_red_in, i_green_in, i_blue_in};
        end
        if (i_cmd.issue) begin
            r_rd_data <= mem[r_idx];
        end
    end

    // Pipeline valid bits
    logic r_v0;
    logic r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.issue;
            r_v1 <= r_v0;
        end
    end

    // Stage 1: absolute differences and squares
    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SQ_W-1:0]       r_sqx;
    logic [SQ_W-1:0]       r_sqy;
    logic [RGB_W-1:0]      r_rgb1;

    assign rd_x = r_rd_data[ENTRY_W-1 -: COORD_BITS];
    assign rd_y = r_rd_data[RGB_W +: COORD_BITS];
    assign dx   = (rd_x >= r_px) ? (rd_x - r_px) : (r_px - rd_x);
    assign dy   = (rd_y >= r_py) ? (rd_y - r_py) : (r_py - rd_y);

    always_ff @(posedge i_clk) begin
        r_sqx  <= SQ_W'(dx) * SQ_W'(dx);
        r_sqy  <= SQ_W'(dy) * SQ_W'(dy);
        r_rgb1 <= r_rd_data[RGB_W-1:0];
    end

    // Stage 2: sum and running minimum; strict compare keeps the first seed on ties
    logic [DIST_W-1:0] sq_sum;
    logic [DIST_W-1:0] r_best;
    logic [RGB_W-1:0]  r_best_rgb;

    assign sq_sum = DIST_W'(r_sqx) + DIST_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_best     <= '1;  // above any reachable distance
            r_best_rgb <= '0;
        end else if (r_v1 && (sq_sum < r_best)) begin
            r_best     <= sq_sum;
            r_best_rgb <= r_rgb1;
        end
    end

    // Output register
    logic                r_out_valid;
    logic [RGB_W-1:0]    r_out_rgb;
    logic [OFFSET_W-1:0] r_out_offset;
    t_status             r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_oob) begin
                r_out_rgb    <= '0;
                r_out_offset <= '0;
                r_out_status <= ST_OUTSIDE;
            end else begin
                r_out_rgb    <= r_best_rgb;
                r_out_offset <= {r_base[OFFSET_W-2:0], 1'b0} + r_base;  // times three
                r_out_status <= r_empty ? ST_NO_SEEDS : ST_OK;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red          = r_out_rgb[RGB_W-1 -: COLOR_W];
    assign o_green        = r_out_rgb[COLOR_W +: COLOR_W];
    assign o_blue         = r_out_rgb[COLOR_W-1:0];
    assign o_pixel_offset = r_out_offset;
    assign o_status_code  = r_out_status;

    // Status back to the controller
    assign o_status.is_pixel  = (i_command == CMD_PIXEL);
    assign o_status.skip      = r_oob || r_empty;
    assign o_status.last      = (r_idx == r_last);
    assign o_status.pipe_busy = r_v0 || r_v1;
    assign o_status.out_free  = !r_out_valid || i_ready;

endmodule

@@ design/nearest_seed_color_lookup_core.sv @@
// Channel     Dir  Handshake      Carries
// i_req       in   valid/ready    load (slot, x, y, rgb) or pixel (x, y)
// o_rsp       out  valid/ready    rgb, pixel_offset, status
// i_cfg_*     in   write enable   seed_count, image_width, image_height
//
// A load item is stored as it is accepted, and the input stays open. A pixel
// scans n seeds, n = seed_count capped at MAX_SEEDS: one seed memory read per
// cycle, then a two-stage distance pipeline drains. Outside or empty: no reads.
// Synchronous active-low reset clears control and config; the seed memory is
// not cleared. A result held in o_rsp does not stop the next item being taken.
//
// Top level of the nearest seed color lookup core; instantiates nscl_ctrl
// and nscl_dp. Depends on nscl_pkg, nscl_req_if, nscl_rsp_if and the macros.
`include "nearest_seed_color_lookup_core_macros.svh"

module nearest_seed_color_lookup_core
    import nscl_pkg::*;
#(
    parameter int MAX_SEEDS  = DEF_MAX_SEEDS,
    parameter int COORD_BITS = DEF_COORD_BITS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nscl_req_if.sink              i_req,
    nscl_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;
    logic       req_ready;
    t_status    status_code;

    // Sequencer
    nscl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .o_ready  (req_ready),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd)
    );

    // Datapath
    nscl_dp #(
        .MAX_SEEDS  (MAX_SEEDS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctrl_cmd),
        .o_status       (dp_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_command      (i_req.command),
        .i_seed_slot    (i_req.seed_slot),
        .i_coord_x      (i_req.coord_x),
        .i_coord_y      (i_req.coord_y),
        .i_red_in       (i_req.red_in),
        .i_green_in     (i_req.green_in),
        .i_blue_in      (i_req.blue_in),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_red          (o_rsp.red),
        .o_green        (o_rsp.green),
        .o_blue         (o_rsp.blue),
        .o_pixel_offset (o_rsp.pixel_offset),
        .o_status_code  (status_code)
    );

    assign i_req.ready  = req_ready;
    assign o_rsp.status = status_code;

    // No new item is taken while seeds are being read
    `NSCL_ASSERT_IMPLY(a_no_accept_during_scan, i_clk, i_rst_n, ctrl_cmd.issue, !req_ready)
    // A pixel transfer closes the input until its result is handed over
    `NSCL_ASSERT_NEXT(a_start_blocks_input, i_clk, i_rst_n, ctrl_cmd.start, !req_ready)
    // A result only enters the output register when it has room
    `NSCL_ASSERT_IMPLY(a_load_into_free_out, i_clk, i_rst_n, ctrl_cmd.load_out, dp_status.out_free)
    // Outside or empty pixels never read the seed memory
    `NSCL_ASSERT_IMPLY(a_skip_no_read, i_clk, i_rst_n, ctrl_cmd.issue, !dp_status.skip)

endmodule

@@ dv/nscl_color_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the nearest seed color lookup core: mirrors the seed table and
// config registers, predicts every pixel result and checks it on output transfer.
// Depends on nscl_pkg, nscl_req_if and nscl_rsp_if.
module nscl_color_checker
    import nscl_pkg::*;
#(
    parameter int MAX_SEEDS = DEF_MAX_SEEDS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nscl_req_if                   i_req,
    nscl_rsp_if                   i_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int          CW       = DEF_COORD_BITS;
    localparam logic [63:0] FAR_AWAY = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [OFFSET_W-1:0] pixel_offset;
        t_status             status;
    } t_color_result;

    // Local copy of the seed memory and registers
    logic [CW-1:0]      seed_x   [MAX_SEEDS];
    logic [CW-1:0]      seed_y   [MAX_SEEDS];
    logic [COLOR_W-1:0] seed_red [MAX_SEEDS];
    logic [COLOR_W-1:0] seed_grn [MAX_SEEDS];
    logic [COLOR_W-1:0] seed_blu [MAX_SEEDS];

    logic [SEED_COUNT_W-1:0] seed_count_q;
    logic [DIM_W-1:0]        width_q;
    logic [DIM_W-1:0]        height_q;

    t_color_result expected_colors[$];
    int            mismatches = 0;

    // Brute-force scan: first seed at the smallest squared distance wins
    function automatic t_color_result nearest_color(input logic [CW-1:0] px,
                                                    input logic [CW-1:0] py);
        t_color_result    res;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int unsigned      n;
        logic [63:0]      best;
        logic [63:0]      sq_sum;
        logic [63:0]      dx;
        logic [63:0]      dy;
        res = '0;
        w = (width_q > DIM_LIMIT) ? DIM_LIMIT : width_q;
        h = (height_q > DIM_LIMIT) ? DIM_LIMIT : height_q;
        if ({1'b0, px} >= w || {1'b0, py} >= h) begin
            res.status = ST_OUTSIDE;
            return res;
        end
        n = (32'(seed_count_q) > MAX_SEEDS) ? MAX_SEEDS : 32'(seed_count_q);
        best = FAR_AWAY;
        for (int i = 0; i < n; i++) begin
            dx = (seed_x[i] >= px) ? 64'(seed_x[i]) - 64'(px) : 64'(px) - 64'(seed_x[i]);
            dy = (seed_y[i] >= py) ? 64'(seed_y[i]) - 64'(py) : 64'(py) - 64'(seed_y[i]);
            sq_sum = dx * dx + dy * dy;
            if (sq_sum < best) begin
                best      = sq_sum;
                res.red   = seed_red[i];
                res.green = seed_grn[i];
                res.blue  = seed_blu[i];
            end
        end
        res.pixel_offset = OFFSET_W'((64'(py) * 64'(w) + 64'(px)) * 64'd3);
        res.status       = (n == 0) ? ST_NO_SEEDS : ST_OK;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_color_result got;
        t_color_result want;
        if (!i_rst_n) begin
            seed_count_q <= '0;
            width_q      <= DIM_RESET;
            height_q     <= DIM_RESET;
            expected_colors.delete();
        end else begin
            // register writes land on the same edge as in the core
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SEED_COUNT:   seed_count_q <= i_cfg_wdata[SEED_COUNT_W-1:0];
                    REG_IMAGE_WIDTH:  width_q      <= i_cfg_wdata[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: height_q     <= i_cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end

            // input transfer: store a seed or queue the predicted color
            if (i_req.valid && i_req.ready) begin
                if (i_req.command == CMD_LOAD) begin
                    if (32'(i_req.seed_slot) < MAX_SEEDS) begin
                        seed_x[i_req.seed_slot]   = i_req.coord_x;
                        seed_y[i_req.seed_slot]   = i_req.coord_y;
                        seed_red[i_req.seed_slot] = i_req.red_in;
                        seed_grn[i_req.seed_slot] = i_req.green_in;
                        seed_blu[i_req.seed_slot] = i_req.blue_in;
                    end
                end else begin
                    expected_colors.push_back(nearest_color(i_req.coord_x, i_req.coord_y));
                end
            end

            // output transfer: compare against the oldest prediction
            if (i_rsp.valid && i_rsp.ready) begin
                got.red          = i_rsp.red;
                got.green        = i_rsp.green;
                got.blue         = i_rsp.blue;
                got.pixel_offset = i_rsp.pixel_offset;
                got.status       = t_status'(i_rsp.status);
                if (expected_colors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("check: unexpected rgb %02x %02x %02x off %0d st %0d",
                                 got.red, got.green, got.blue, got.pixel_offset, got.status);
                end else begin
                    want = expected_colors.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("check: mismatch exp rgb %02x %02x %02x off %0d st %0d, %s",
                                     want.red, want.green, want.blue, want.pixel_offset,
                                     want.status,
                                     $sformatf("got rgb %02x %02x %02x off %0d st %0d",
                                               got.red, got.green, got.blue,
                                               got.pixel_offset, got.status));
                    end
                end
            end
        end
        o_pending    <= expected_colors.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Top of the nearest seed color lookup testbench: clock, reset, seed/pixel
// stimulus, config phases and output back-pressure; nscl_color_checker judges.
// Depends on nscl_pkg, nscl_req_if, nscl_rsp_if and the core.
module tb
    import nscl_pkg::*;
;

    localparam int          MAX_SEEDS  = DEF_MAX_SEEDS;
    localparam int          N_ITEMS    = 1700;
    localparam int          SETTLE     = 8;
    localparam int          LONG_HOLD  = 600;
    localparam int          TAIL       = 100;
    localparam longint      TIMEOUT_NS = 64'd20_000_000;

    typedef struct {
        t_cmd               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [11:0]        x;
        logic [11:0]        y;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_lookup_item;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_reg              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    pending;

    bit                    hold_off_req = 1'b0;
    bit                    burst        = 1'b0;
    bit                    clustered    = 1'b0;
    logic [MAX_SEEDS-1:0]  seeds_loaded = '0;
    int unsigned           cur_sc;
    int unsigned           cur_w;
    int unsigned           cur_h;
    int                    items_sent   = 0;

    nscl_req_if req_ch ();
    nscl_rsp_if rsp_ch ();

    nearest_seed_color_lookup_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    nscl_color_checker #(.MAX_SEEDS(MAX_SEEDS)) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly short gaps, a few long ones; none during a burst
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_dim();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 0;
            1:       return 1;
            2:       return 4096;
            3:       return $urandom_range(4097, 8191);
            4, 5, 6, 7, 8: return $urandom_range(1, 32);
            default: return $urandom_range(33, 4096);
        endcase
    endfunction

    function automatic t_lookup_item load_item(input int unsigned slot, input int unsigned x,
                                               input int unsigned y, input int unsigned r,
                                               input int unsigned g, input int unsigned b);
        t_lookup_item it;
        it.cmd   = CMD_LOAD;
        it.slot  = SLOT_W'(slot);
        it.x     = 12'(x);
        it.y     = 12'(y);
        it.red   = COLOR_W'(r);
        it.green = COLOR_W'(g);
        it.blue  = COLOR_W'(b);
        return it;
    endfunction

    // slot and color fields carry noise; a pixel query must ignore them
    function automatic t_lookup_item pixel_item(input int unsigned x, input int unsigned y);
        t_lookup_item it;
        it     = load_item($urandom, x, y, $urandom, $urandom, $urandom);
        it.cmd = CMD_PIXEL;
        return it;
    endfunction

    // clustered seeds sit in a small corner so that ties turn up often
    function automatic t_lookup_item random_load(input int unsigned slot);
        if (clustered)
            return load_item(slot, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom, $urandom, $urandom);
        return load_item(slot, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic t_lookup_item random_pixel();
        int unsigned r;
        int unsigned lim;
        r = $urandom_range(0, 9);
        if (r < 8 && cur_w > 0 && cur_h > 0) begin
            if (clustered && r < 3) begin
                lim = (cur_w > 40) ? 40 : cur_w - 1;
                return pixel_item($urandom_range(0, lim),
                                  $urandom_range(0, (cur_h > 40) ? 40 : cur_h - 1));
            end
            return pixel_item($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
        end
        if (r == 8)
            return pixel_item($urandom, $urandom);
        // just past the right edge, or the last column when the width is full
        return pixel_item((cur_w > 4095) ? 4095 : cur_w, $urandom);
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(input t_lookup_item it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= it.cmd;
        req_ch.seed_slot <= it.slot;
        req_ch.coord_x   <= it.x;
        req_ch.coord_y   <= it.y;
        req_ch.red_in    <= it.red;
        req_ch.green_in  <= it.green;
        req_ch.blue_in   <= it.blue;
        do @(posedge clk); while (!req_ch.ready);
        if (it.cmd == CMD_LOAD)
            seeds_loaded[it.slot] = 1'b1;
        items_sent++;
    endtask

    // Drain, write all registers while idle, then load each slot a scan reaches that is not yet loaded
    task automatic configure(input int unsigned sc, input int unsigned w, input int unsigned h);
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SEED_COUNT;
        cfg_wdata <= CFG_DATA_W'(sc);
        @(posedge clk);
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_sc = (sc > MAX_SEEDS) ? MAX_SEEDS : sc;
        cur_w  = (w > 4096) ? 4096 : w;
        cur_h  = (h > 4096) ? 4096 : h;
        for (int s = 0; s < cur_sc; s++)
            if (!seeds_loaded[s])
                send_item(random_load(s));
    endtask

    // Output side: random stalls, occasional long ready stretches, one long hold-off
    initial begin : result_side
        int unsigned on_len;
        int unsigned off_len;
        int unsigned r;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            on_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 8);
            rsp_ch.ready <= 1'b1;
            repeat (on_len) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 50)      off_len = 0;
            else if (r < 85) off_len = $urandom_range(1, 3);
            else if (r < 97) off_len = $urandom_range(4, 15);
            else             off_len = $urandom_range(30, 80);
            if (off_len > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (off_len) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int unsigned r;
        int unsigned sc;
        int unsigned phase;
        int unsigned n_phase;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_SEED_COUNT;
        cfg_wdata        <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.command   <= CMD_LOAD;
        req_ch.seed_slot <= '0;
        req_ch.coord_x   <= '0;
        req_ch.coord_y   <= '0;
        req_ch.red_in    <= '0;
        req_ch.green_in  <= '0;
        req_ch.blue_in   <= '0;
        cur_sc = 0;
        cur_w  = 512;
        cur_h  = 512;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: empty table, 512 x 512 image
        send_item(pixel_item(0, 0));
        send_item(pixel_item(511, 511));
        send_item(pixel_item(512, 5));
        send_item(pixel_item(7, 512));
        send_item(pixel_item(4095, 4095));
        send_item(load_item(0, 10, 10, 255, 0, 0));
        send_item(load_item(1, 12, 10, 0, 255, 0));
        send_item(load_item(63, 4095, 4095, 255, 255, 255));
        send_item(load_item(2, 0, 0, 0, 0, 0));

        // equal distance to seeds 0 and 1: the lower slot keeps it
        configure(2, 512, 512);
        send_item(pixel_item(11, 10));
        send_item(pixel_item(12, 10));
        send_item(pixel_item(0, 0));

        // oversized count and dimensions saturate
        configure(127, 8191, 8191);
        send_item(pixel_item(4095, 4095));
        send_item(pixel_item(0, 0));
        send_item(pixel_item(4095, 0));

        // zero width or height: every pixel falls outside
        configure(64, 0, 4096);
        send_item(pixel_item(0, 0));
        configure(1, 4096, 0);
        send_item(pixel_item(0, 0));

        // one-pixel image
        configure(64, 1, 1);
        send_item(pixel_item(0, 0));
        send_item(pixel_item(1, 0));
        send_item(pixel_item(0, 1));

        // random phases, each with fresh register settings
        phase = 0;
        while (items_sent < N_ITEMS) begin
            clustered = ($urandom_range(0, 4) < 2);
            r = $urandom_range(0, 9);
            case (r)
                0:       sc = 0;
                1:       sc = 1;
                2:       sc = 64;
                3:       sc = $urandom_range(65, 127);
                default: sc = $urandom_range(2, 40);
            endcase
            configure(sc, pick_dim(), pick_dim());
            burst = ($urandom_range(0, 5) == 0);
            // back-to-back items against a long output hold-off
            if (phase == 2) begin
                burst        = 1'b1;
                hold_off_req = 1'b1;
            end
            n_phase = $urandom_range(30, 120);
            repeat (n_phase) begin
                if ($urandom_range(0, 99) < 40)
                    send_item(random_load($urandom_range(0, MAX_SEEDS - 1)));
                else
                    send_item(random_pixel());
            end
            burst = 1'b0;
            phase++;
        end

        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/nscl_pkg.sv
design/nscl_req_if.sv
design/nscl_rsp_if.sv
design/nscl_ctrl.sv
design/nscl_dp.sv
design/nearest_seed_color_lookup_core.sv
dv/nscl_color_checker.sv
dv/tb.sv
